// ----- hw/rtl/lkdw_pkg.sv -----
// Package for the longest k-distinct window block.
// Holds widths, the cell mode codes, the cell link structs and register indexes.
// No dependencies.
package lkdw_pkg;

	localparam int unsigned LKDW_K_MAX = 16;
	localparam int unsigned VALUE_W = 32;
	localparam int unsigned POS_W = 20;
	localparam int unsigned CNT_W = POS_W + 1;
	localparam int unsigned SEG_W = 21;
	localparam int unsigned LIMIT_W = 5;
	localparam int unsigned APB_DATA_W = 32;
	localparam int unsigned APB_ADDR_W = 3;
	localparam logic [CNT_W-1:0] MAX_ITEMS = CNT_W'(1) << POS_W;

	// Register index, taken from the word address bit of paddr.
	localparam logic REG_DISTINCT_LIMIT = 1'b0;

	typedef enum logic [1:0] {
		MODE_HIT   = 2'd0,
		MODE_FILL  = 2'd1,
		MODE_EVICT = 2'd2
	} lkdw_mode_t;

	typedef struct packed {
		logic               load;
		logic               clear;
		lkdw_mode_t         mode;
		logic [VALUE_W-1:0] value;
		logic [POS_W-1:0]   pos;
	} cell_cmd_t;

	typedef struct packed {
		logic               valid;
		logic [VALUE_W-1:0] value;
		logic [POS_W-1:0]   pos;
	} cell_fwd_t;

	typedef struct packed {
		logic             valid;
		logic             hit;
		logic [POS_W-1:0] tail_pos;
	} cell_bwd_t;

endpackage

// ----- hw/rtl/longest_k_distinct_window.sv -----
// Top level of the longest k-distinct window block: control, registers, output stage.
// Depends on lkdw_pkg and lkdw_chain.
//
// The block takes one sample word per clock cycle and, on the word flagged as end of
// sequence, delivers one result word with the 1-based first and last positions of the
// longest window seen that holds at most distinct_limit distinct values (0 counts as 1,
// and a limit above K_MAX as K_MAX). The path that sets the clock is the value compare
// in every cell followed by the hit and tail signals that ripple through the K_MAX cells
// of the chain. The input stalls only when an end-of-sequence word arrives while the
// previous result is still stalled at the output. After the end-of-sequence word all
// state but distinct_limit and the output is reset; the next word starts a new sequence.
module longest_k_distinct_window import lkdw_pkg::*; #(
	parameter int unsigned K_MAX = LKDW_K_MAX
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	input  logic                  sample_valid,
	output logic                  sample_stall,
	input  logic [VALUE_W-1:0]    sample_value,
	input  logic                  end_of_sequence,
	output logic                  segment_valid,
	input  logic                  segment_stall,
	output logic [SEG_W-1:0]      segment_first,
	output logic [SEG_W-1:0]      segment_final
);

	localparam int unsigned USED_W = $clog2(K_MAX + 1);
	localparam int unsigned CMP_W = (USED_W > LIMIT_W) ? USED_W : LIMIT_W;

	logic [LIMIT_W-1:0] limit_q;
	logic [USED_W-1:0]  used_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [POS_W-1:0]   start_q;
	logic [SEG_W-1:0]   len_q;
	logic [SEG_W-1:0]   best_len_q;
	logic [POS_W-1:0]   best_first_q;
	logic [POS_W-1:0]   best_last_q;
	logic               out_valid_q;
	logic [SEG_W-1:0]   out_first_q;
	logic [SEG_W-1:0]   out_final_q;

	logic               accept;
	logic               take;
	logic               finish;
	logic [POS_W-1:0]   idx;
	logic [CMP_W-1:0]   limit_ext;
	logic [CMP_W-1:0]   limit_eff;
	logic               fill_ok;
	logic               full;
	lkdw_mode_t         mode;
	cell_cmd_t          cmd;
	cell_bwd_t          head;

	logic [POS_W-1:0]   start_n;
	logic [SEG_W-1:0]   len_n;
	logic [SEG_W-1:0]   best_len_n;
	logic [POS_W-1:0]   best_first_n;
	logic [POS_W-1:0]   best_last_n;
	logic [POS_W-1:0]   res_first;
	logic [POS_W-1:0]   res_last;

	// Configuration port.
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_DISTINCT_LIMIT) ? APB_DATA_W'(limit_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_W'(1);
		end else if (psel && penable && pwrite && pready && (paddr[2] == REG_DISTINCT_LIMIT)) begin
			limit_q <= pwdata[LIMIT_W-1:0];
		end
	end

	// Handshake and step control.
	assign sample_stall = out_valid_q && segment_stall && end_of_sequence;
	assign accept = sample_valid && !sample_stall;
	assign take = accept && (cnt_q < MAX_ITEMS);
	assign finish = accept && end_of_sequence;
	assign idx = cnt_q[POS_W-1:0];

	assign limit_ext = CMP_W'(limit_q);
	always_comb begin
		if (limit_ext == '0) begin
			limit_eff = CMP_W'(1);
		end else if (limit_ext > CMP_W'(K_MAX)) begin
			limit_eff = CMP_W'(K_MAX);
		end else begin
			limit_eff = limit_ext;
		end
	end
	assign fill_ok = !full && (CMP_W'(used_q) < limit_eff);

	always_comb begin
		if (head.hit) begin
			mode = MODE_HIT;
		end else if (fill_ok) begin
			mode = MODE_FILL;
		end else begin
			mode = MODE_EVICT;
		end
	end

	assign cmd = '{load: take, clear: finish, mode: mode, value: sample_value, pos: idx};

	lkdw_chain #(
		.K_MAX (K_MAX)
	) u_chain (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.head   (head),
		.full   (full)
	);

	// Window and best-window update for the current word.
	always_comb begin
		start_n = start_q;
		len_n = len_q;
		best_len_n = best_len_q;
		best_first_n = best_first_q;
		best_last_n = best_last_q;
		if (take) begin
			if (mode == MODE_EVICT) begin
				if (len_q >= best_len_q) begin
					best_len_n = len_q;
					best_first_n = start_q;
					best_last_n = idx - POS_W'(1);
				end
				start_n = head.tail_pos + POS_W'(1);
				len_n = SEG_W'(idx - start_n) + SEG_W'(1);
			end else begin
				len_n = len_q + SEG_W'(1);
			end
		end
	end

	always_comb begin
		if (len_n > best_len_n) begin
			res_first = start_n;
			res_last = take ? idx : POS_W'(cnt_q - CNT_W'(1));
		end else begin
			res_first = best_first_n;
			res_last = best_last_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			cnt_q <= '0;
			start_q <= '0;
			len_q <= '0;
			best_len_q <= '0;
			best_first_q <= '0;
			best_last_q <= '0;
		end else if (finish) begin
			used_q <= '0;
			cnt_q <= '0;
			start_q <= '0;
			len_q <= '0;
			best_len_q <= '0;
			best_first_q <= '0;
			best_last_q <= '0;
		end else if (take) begin
			if (mode == MODE_FILL) begin
				used_q <= used_q + USED_W'(1);
			end
			cnt_q <= cnt_q + CNT_W'(1);
			start_q <= start_n;
			len_q <= len_n;
			best_len_q <= best_len_n;
			best_first_q <= best_first_n;
			best_last_q <= best_last_n;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (!segment_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			out_first_q <= SEG_W'(res_first) + SEG_W'(1);
			out_final_q <= SEG_W'(res_last) + SEG_W'(1);
		end
	end

	assign segment_valid = out_valid_q;
	assign segment_first = out_first_q;
	assign segment_final = out_final_q;

endmodule

// ----- hw/rtl/lkdw_cell.sv -----
// One cell of the recency-ordered entry chain: a value with its last position.
// Depends on lkdw_pkg.
module lkdw_cell import lkdw_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cell_cmd_t cmd,
	input  cell_fwd_t up,
	output cell_fwd_t fwd,
	input  cell_bwd_t down,
	output cell_bwd_t bwd
);

	logic               valid_q;
	logic [VALUE_W-1:0] value_q;
	logic [POS_W-1:0]   pos_q;
	logic               own_hit;
	logic               shift;

	assign own_hit = valid_q && (value_q == cmd.value);

	assign bwd.valid = valid_q;
	assign bwd.hit = own_hit | down.hit;
	assign bwd.tail_pos = (valid_q && !down.valid) ? pos_q : down.tail_pos;

	assign fwd.valid = valid_q;
	assign fwd.value = value_q;
	assign fwd.pos = pos_q;

	always_comb begin
		unique case (cmd.mode)
			MODE_HIT:   shift = own_hit | down.hit;
			MODE_FILL:  shift = up.valid;
			MODE_EVICT: shift = valid_q;
			default:    shift = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.clear) begin
			valid_q <= 1'b0;
		end else if (cmd.load && shift) begin
			valid_q <= up.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load && shift) begin
			value_q <= up.value;
			pos_q <= up.pos;
		end
	end

endmodule

// ----- hw/rtl/lkdw_chain.sv -----
// Chain of entry cells, most recent entry at the head.
// Depends on lkdw_pkg and lkdw_cell.
module lkdw_chain import lkdw_pkg::*; #(
	parameter int unsigned K_MAX = LKDW_K_MAX
) (
	input  logic      clk,
	input  logic      arst_n,
	input  cell_cmd_t cmd,
	output cell_bwd_t head,
	output logic      full
);

	cell_fwd_t up [0:K_MAX];
	cell_bwd_t bk [0:K_MAX];

	assign up[0] = '{valid: 1'b1, value: cmd.value, pos: cmd.pos};
	assign bk[K_MAX] = '0;
	assign head = bk[0];
	assign full = up[K_MAX].valid;

	for (genvar i = 0; i < K_MAX; i++) begin : g_cell
		lkdw_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.cmd    (cmd),
			.up     (up[i]),
			.fwd    (up[i+1]),
			.down   (bk[i+1]),
			.bwd    (bk[i])
		);
	end

endmodule

// ----- hw/rtl/lkdw_checker.sv -----
// Port-level checker for the longest k-distinct window block, bound to the top level.
// Depends on lkdw_pkg and longest_k_distinct_window.
module lkdw_checker import lkdw_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               sample_valid,
	input logic               sample_stall,
	input logic               end_of_sequence,
	input logic               segment_valid,
	input logic               segment_stall,
	input logic [SEG_W-1:0]   segment_first,
	input logic [SEG_W-1:0]   segment_final
);

	// A result word is stable while it is stalled.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		segment_valid && segment_stall |=> segment_valid && $stable(segment_first)
			&& $stable(segment_final))
		else $error("stalled result word changed");

	// A result word leaves only when it is taken.
	a_out_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(segment_valid) |-> $past(!segment_stall))
		else $error("result word dropped while stalled");

	// An accepted end-of-sequence word yields a result in the next cycle.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && !sample_stall && end_of_sequence |=> segment_valid)
		else $error("no result after end of sequence");

	// The window bounds are 1-based and ordered.
	a_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		segment_valid |-> (segment_first != '0) && (segment_first <= segment_final))
		else $error("result window bounds out of order");

endmodule

bind longest_k_distinct_window lkdw_checker u_lkdw_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.sample_valid    (sample_valid),
	.sample_stall    (sample_stall),
	.end_of_sequence (end_of_sequence),
	.segment_valid   (segment_valid),
	.segment_stall   (segment_stall),
	.segment_first   (segment_first),
	.segment_final   (segment_final)
);
